FILE: sv/deq_pkg.sv
`timescale 1ns / 1ps
// Package for the double-ended queue with positional insert.
// Holds sizes, command/status/state codes, the memory request struct and ring index helpers.
// No dependencies.
package deq_pkg;

    // Ring size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int DATA_W   = 32;
    localparam int POS_W    = 5;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Stream packing widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_QUERY      = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SHIFT,
        S_PLACE,
        S_HOLD
    } t_state;

    // One write port and one read port per cycle
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

    // Slot of an entry at offset from the head, wrapping around the ring
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IDX_W+1)'(CAPACITY)) begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Slot just ahead of the head
    function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] head);
        logic [IDX_W-1:0] res;
        if (head == '0) begin
            res = IDX_W'(CAPACITY - 1);
        end else begin
            res = head - 1'b1;
        end
        return res;
    endfunction

endpackage

FILE: sv/deq_ram.sv
`timescale 1ns / 1ps
// Entry store of the queue: one write port, one read port, registered read data.
// Depends on deq_pkg.
module deq_ram (
    input  logic                     i_clk,
    input  deq_pkg::t_mem_req        i_req,
    output logic [deq_pkg::DATA_W-1:0] o_rd_data
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/deq_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer of the queue: head/count, cached end values, insert shift loop,
// and the result register. Depends on deq_pkg; drives the deq_ram request.
module deq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [deq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [deq_pkg::DATA_W-1:0]    i_value,
    input  logic [deq_pkg::POS_W-1:0]     i_position,
    output deq_pkg::t_mem_req             o_mem_req,
    input  logic [deq_pkg::DATA_W-1:0]    i_mem_rd_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [deq_pkg::STATUS_W-1:0]  o_status,
    output logic [deq_pkg::DATA_W-1:0]    o_front,
    output logic [deq_pkg::DATA_W-1:0]    o_back,
    output logic [deq_pkg::COUNT_W-1:0]   o_count
);
    import deq_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_front, n_front;
    logic [DATA_W-1:0] r_back, n_back;
    t_status           r_status, n_status;
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_value;
    logic [POS_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_idx, n_idx;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_front;
    logic [DATA_W-1:0] r_out_back;
    logic [COUNT_W-1:0] r_out_count;

    logic              accept;
    logic              finish;
    logic              out_free;
    logic              publish;
    logic              is_full;
    logic              is_empty;
    logic              do_push_front;
    logic              do_push_back;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  idx_prev_ext;
    logic [CNT_W-1:0]  idx_prev;
    t_mem_req          mem_req;

    assign out_free     = !r_out_valid || i_out_ready;
    assign is_full      = (r_count == CNT_W'(CAPACITY));
    assign is_empty     = (r_count == '0);
    assign pos_ext      = CMP_W'(r_pos);
    assign cnt_ext      = CMP_W'(r_count);
    assign idx_prev     = r_idx - 1'b1;
    assign idx_prev_ext = CMP_W'(idx_prev);
    assign o_in_ready   = (r_state == S_IDLE);
    assign accept       = i_in_valid && o_in_ready;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    // Cached end values, command latch and shift index
    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_back  <= n_back;
        r_idx   <= n_idx;
        if (accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_value <= i_value;
            r_pos   <= i_position;
        end
    end

    // Next state, memory requests and completion
    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_count       = r_count;
        n_front       = r_front;
        n_back        = r_back;
        n_status      = r_status;
        n_idx         = r_idx;
        finish        = 1'b0;
        do_push_front = 1'b0;
        do_push_back  = 1'b0;
        mem_req       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status = ST_OK;
                unique case (r_cmd)
                    CMD_PUSH_FRONT: begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            do_push_front = 1'b1;
                        end
                        finish = 1'b1;
                    end
                    CMD_PUSH_BACK: begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            do_push_back = 1'b1;
                        end
                        finish = 1'b1;
                    end
                    CMD_POP_FRONT: begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                            finish   = 1'b1;
                        end else begin
                            n_head  = slot_of(r_head, IDX_W'(1));
                            n_count = r_count - 1'b1;
                            if (r_count == CNT_W'(1)) begin
                                finish = 1'b1;
                            end else begin
                                // new front sits one slot behind the old one
                                mem_req.re    = 1'b1;
                                mem_req.raddr = slot_of(r_head, IDX_W'(1));
                                n_state       = S_POP_WAIT;
                            end
                        end
                    end
                    CMD_POP_BACK: begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                            finish   = 1'b1;
                        end else begin
                            n_count = r_count - 1'b1;
                            if (r_count == CNT_W'(1)) begin
                                finish = 1'b1;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = slot_of(r_head, IDX_W'(r_count - CNT_W'(2)));
                                n_state       = S_POP_WAIT;
                            end
                        end
                    end
                    CMD_INSERT: begin
                        if (pos_ext > cnt_ext) begin
                            n_status = ST_INVALID;
                            finish   = 1'b1;
                        end else if (is_full) begin
                            n_status = ST_FULL;
                            finish   = 1'b1;
                        end else if (pos_ext == '0) begin
                            do_push_front = 1'b1;
                            finish        = 1'b1;
                        end else if (pos_ext == cnt_ext) begin
                            do_push_back = 1'b1;
                            finish       = 1'b1;
                        end else begin
                            // start moving entries back, last one first
                            mem_req.re    = 1'b1;
                            mem_req.raddr = slot_of(r_head, IDX_W'(r_count - 1'b1));
                            n_idx         = r_count;
                            n_state       = S_SHIFT;
                        end
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase

                if (do_push_front) begin
                    n_head        = slot_dec(r_head);
                    n_count       = r_count + 1'b1;
                    n_front       = r_value;
                    mem_req.we    = 1'b1;
                    mem_req.waddr = slot_dec(r_head);
                    mem_req.wdata = r_value;
                    if (is_empty) begin
                        n_back = r_value;
                    end
                end
                if (do_push_back) begin
                    n_count       = r_count + 1'b1;
                    n_back        = r_value;
                    mem_req.we    = 1'b1;
                    mem_req.waddr = slot_of(r_head, IDX_W'(r_count));
                    mem_req.wdata = r_value;
                    if (is_empty) begin
                        n_front = r_value;
                    end
                end
            end

            S_POP_WAIT: begin
                if (r_cmd == CMD_POP_FRONT) begin
                    n_front = i_mem_rd_data;
                end else begin
                    n_back = i_mem_rd_data;
                end
                finish = 1'b1;
            end

            // Read of offset idx-1 landed: write it to offset idx
            S_SHIFT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = slot_of(r_head, IDX_W'(r_idx));
                mem_req.wdata = i_mem_rd_data;
                if (idx_prev_ext > pos_ext) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = slot_of(r_head, IDX_W'(idx_prev - 1'b1));
                    n_idx         = idx_prev;
                end else begin
                    n_state = S_PLACE;
                end
            end

            S_PLACE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = slot_of(r_head, IDX_W'(r_pos));
                mem_req.wdata = r_value;
                n_count       = r_count + 1'b1;
                finish        = 1'b1;
            end

            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_state = out_free ? S_IDLE : S_HOLD;
        end
    end

    assign publish   = out_free && (finish || (r_state == S_HOLD));
    assign o_mem_req = mem_req;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (publish) begin
            r_out_status <= n_status;
            r_out_count  <= COUNT_W'(n_count);
            r_out_front  <= (n_count == '0) ? EMPTY_VALUE : n_front;
            r_out_back   <= (n_count == '0) ? EMPTY_VALUE : n_back;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_front     = r_out_front;
    assign o_back      = r_out_back;
    assign o_count     = r_out_count;

endmodule

FILE: sv/deque_with_positional_insert.sv
`timescale 1ns / 1ps
// From input accept to result valid: push, query, failed commands and a pop that empties
// the queue finish in S_EXEC; a pop that leaves entries adds S_POP_WAIT (one memory read);
// an inner insert passes S_SHIFT (one entry moved per cycle through the single RAM port pair), then S_PLACE.
// One command at a time; the next input is taken while a result waits in the output register.
// Reset (synchronous, active low) empties the queue and drops any pending result; the entry
// RAM is not cleared, only written slots are ever read.
module deque_with_positional_insert (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [deq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // value[31:0], position[36:32]
    input  logic [deq_pkg::CMD_W-1:0]       s_axis_tuser,  // cmd[2:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [deq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // front[31:0], back[63:32], count[68:64]
    output logic [deq_pkg::STATUS_W-1:0]    m_axis_tuser   // status[1:0]
);
    import deq_pkg::*;

    t_mem_req           mem_req;
    logic [DATA_W-1:0]  mem_rd_data;
    logic [DATA_W-1:0]  out_front;
    logic [DATA_W-1:0]  out_back;
    logic [COUNT_W-1:0] out_count;

    // Sequencer
    deq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_value       (s_axis_tdata[DATA_W-1:0]),
        .i_position    (s_axis_tdata[DATA_W +: POS_W]),
        .o_mem_req     (mem_req),
        .i_mem_rd_data (mem_rd_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (m_axis_tuser),
        .o_front       (out_front),
        .o_back        (out_back),
        .o_count       (out_count)
    );

    // Entry store
    deq_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (mem_rd_data)
    );

    // Result packing, zero padded to whole bytes
    assign m_axis_tdata = {(OUT_TDATA_W - 2*DATA_W - COUNT_W)'(0), out_count, out_back, out_front};

endmodule

FILE: sv/deq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg and deque_with_positional_insert.
module deq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [deq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [deq_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import deq_pkg::*;

    logic [DATA_W-1:0]  chk_front;
    logic [DATA_W-1:0]  chk_back;
    logic [COUNT_W-1:0] chk_count;

    assign chk_front = m_axis_tdata[DATA_W-1:0];
    assign chk_back  = m_axis_tdata[DATA_W +: DATA_W];
    assign chk_count = m_axis_tdata[2*DATA_W +: COUNT_W];

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One command in flight: input closes after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a command is in flight");

    // Empty queue reports -1 at both ends
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && chk_count == '0 |-> chk_front == EMPTY_VALUE && chk_back == EMPTY_VALUE)
        else $error("empty queue with end values other than -1");

    // Full status only at capacity, empty status only at zero
    a_status_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != ST_FULL || chk_count == COUNT_W'(CAPACITY))
            && (m_axis_tuser != ST_EMPTY || chk_count == '0))
        else $error("status does not match count");

endmodule

bind deque_with_positional_insert deq_checker u_deq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/deque_with_positional_insert_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue with positional insert.
// Needs deq_pkg and deque_with_positional_insert; a built-in predictor tracks the ring
// and checks every result transaction.
module deque_with_positional_insert_tb;
    import deq_pkg::*;

    localparam int        WATCHDOG_LIMIT = 2000;
    localparam int        TAIL_CYCLES    = 40;
    localparam int        RANDOM_CMDS    = 1100;
    // Codes outside the command list; the block treats them as a query
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_ZERO = 32'h0000_0000;
    localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

    // One command transaction plus its sender timing
    typedef struct {
        logic [CMD_W-1:0]  op;
        logic [DATA_W-1:0] val;
        logic [POS_W-1:0]  pos;
        int                gap;
        bit                hold;  // wait until all results are back before sending
    } t_deq_cmd;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   front;
        logic [DATA_W-1:0]   back;
        logic [COUNT_W-1:0]  count;
    } t_deq_reply;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // value[31:0], position[36:32]
    logic [CMD_W-1:0]       s_axis_tuser  = '0;  // cmd[2:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // front[31:0], back[63:32], count[68:64]
    logic [STATUS_W-1:0]    m_axis_tuser;        // status[1:0]

    deque_with_positional_insert i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predictor state: ring contents, head slot and fill level
    logic [DATA_W-1:0] ring_val [CAPACITY];
    int                ring_head = 0;
    int                ring_fill = 0;

    t_deq_cmd   cmd_queue[$];
    t_deq_reply predicted_replies[$];
    t_deq_cmd   cmd_on_bus;
    int         cmds_total    = 0;
    int         cmds_accepted = 0;
    int         mismatches    = 0;
    int         idle_cycles   = 0;

    // Generator bookkeeping: fill level seen by the stimulus, idling mode, sync request
    int gen_fill  = 0;
    bit gen_calm  = 1'b0;
    bit hold_next = 1'b0;

    // Receiver stall state
    int rx_wait    = 0;
    int rx_results = 0;
    bit rx_calm    = 1'b0;

    // Applies one command to the ring and returns the reply the block must give
    function automatic t_deq_reply apply_command(input t_deq_cmd c);
        t_deq_reply r;
        int         k;
        r.status = ST_OK;
        case (c.op)
            CMD_PUSH_FRONT: begin
                if (ring_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    ring_head = (ring_head + CAPACITY - 1) % CAPACITY;
                    ring_val[ring_head] = c.val;
                    ring_fill++;
                end
            end
            CMD_PUSH_BACK: begin
                if (ring_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    ring_val[(ring_head + ring_fill) % CAPACITY] = c.val;
                    ring_fill++;
                end
            end
            CMD_POP_FRONT: begin
                if (ring_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    ring_head = (ring_head + 1) % CAPACITY;
                    ring_fill--;
                end
            end
            CMD_POP_BACK: begin
                if (ring_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    ring_fill--;
                end
            end
            CMD_INSERT: begin
                // Position check wins over the full check
                if (int'(c.pos) > ring_fill) begin
                    r.status = ST_INVALID;
                end else if (ring_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (c.pos == '0) begin
                    ring_head = (ring_head + CAPACITY - 1) % CAPACITY;
                    ring_val[ring_head] = c.val;
                    ring_fill++;
                end else begin
                    for (k = ring_fill; k > int'(c.pos); k--) begin
                        ring_val[(ring_head + k) % CAPACITY] =
                            ring_val[(ring_head + k - 1) % CAPACITY];
                    end
                    ring_val[(ring_head + int'(c.pos)) % CAPACITY] = c.val;
                    ring_fill++;
                end
            end
            default: begin
            end
        endcase
        if (ring_fill == 0) begin
            r.front = EMPTY_VALUE;
            r.back  = EMPTY_VALUE;
        end else begin
            r.front = ring_val[ring_head];
            r.back  = ring_val[(ring_head + ring_fill - 1) % CAPACITY];
        end
        r.count = COUNT_W'(ring_fill);
        return r;
    endfunction

    // Queues one command and tracks the fill level it leads to
    task automatic add_cmd(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val,
                           input logic [POS_W-1:0] pos);
        t_deq_cmd c;
        c.op   = op;
        c.val  = val;
        c.pos  = pos;
        c.gap  = gen_calm ? 0 : $urandom_range(0, 11);
        c.hold = hold_next;
        hold_next = 1'b0;
        cmd_queue.insert(cmd_queue.size(), c);
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (gen_fill < CAPACITY) gen_fill++;
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (gen_fill > 0) gen_fill--;
            end
            CMD_INSERT: begin
                if (int'(pos) <= gen_fill && gen_fill < CAPACITY) gen_fill++;
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = VAL_ZERO;
                default: v = VAL_NEG1;
            endcase
        end
        return v;
    endfunction

    // One random command; mode 0 leans to growing, 1 to shrinking, 2 is balanced
    task automatic add_random_cmd(input int mode);
        int                r;
        logic [CMD_W-1:0]  op;
        logic [POS_W-1:0]  pos;
        r   = $urandom_range(0, 99);
        pos = POS_W'($urandom_range(0, gen_fill));
        case (mode)
            0: op = (r < 30) ? CMD_PUSH_BACK : (r < 55) ? CMD_PUSH_FRONT :
                    (r < 85) ? CMD_INSERT : (r < 90) ? CMD_POP_FRONT :
                    (r < 94) ? CMD_POP_BACK : CMD_QUERY;
            1: op = (r < 35) ? CMD_POP_FRONT : (r < 70) ? CMD_POP_BACK :
                    (r < 78) ? CMD_PUSH_BACK : (r < 84) ? CMD_PUSH_FRONT :
                    (r < 94) ? CMD_INSERT : CMD_QUERY;
            default: op = (r < 18) ? CMD_PUSH_BACK : (r < 36) ? CMD_PUSH_FRONT :
                          (r < 54) ? CMD_POP_FRONT : (r < 72) ? CMD_POP_BACK :
                          (r < 92) ? CMD_INSERT : CMD_QUERY;
        endcase
        // Noise: spare codes and out-of-range positions
        if (op == CMD_QUERY && $urandom_range(0, 2) != 0) begin
            op = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
        end
        if (op == CMD_INSERT && $urandom_range(0, 9) == 0) begin
            pos = POS_W'($urandom_range(gen_fill + 1, 31));
        end
        if (op != CMD_INSERT && $urandom_range(0, 1) == 0) begin
            pos = POS_W'($urandom);
        end
        add_cmd(op, pick_value(), pos);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stimulus build-up, reset and end of run
    initial begin
        int burst;
        int mode;
        int n;
        int sync_at;

        // Empty-store cases
        add_cmd(CMD_QUERY, VAL_ZERO, '0);
        add_cmd(CMD_POP_FRONT, VAL_ZERO, '0);
        add_cmd(CMD_POP_BACK, VAL_ZERO, '0);
        add_cmd(CMD_INSERT, $urandom, 5'd1);
        // Insert at the front and at the back, then an inner insert
        add_cmd(CMD_INSERT, VAL_MIN, 5'd0);
        add_cmd(CMD_PUSH_BACK, VAL_MAX, '0);
        add_cmd(CMD_PUSH_FRONT, VAL_ZERO, '0);
        add_cmd(CMD_INSERT, VAL_NEG1, 5'd3);
        add_cmd(CMD_INSERT, $urandom, 5'd1);
        add_cmd(CMD_INSERT, $urandom, 5'd31);
        add_cmd(CMD_SPARE_LO, $urandom, '0);
        add_cmd(CMD_SPARE_HI, $urandom, '0);
        add_cmd(CMD_POP_FRONT, VAL_ZERO, '0);
        add_cmd(CMD_POP_BACK, VAL_ZERO, '0);
        // Fill up with inserts at assorted positions
        while (gen_fill < CAPACITY) begin
            add_cmd(CMD_INSERT, $urandom, POS_W'($urandom_range(0, gen_fill)));
        end
        // Full-store cases
        add_cmd(CMD_PUSH_FRONT, $urandom, '0);
        add_cmd(CMD_PUSH_BACK, $urandom, '0);
        add_cmd(CMD_INSERT, $urandom, 5'd16);
        add_cmd(CMD_INSERT, $urandom, 5'd17);

        // Random bursts with their own bias and idling mode
        hold_next = 1'b1;
        sync_at   = RANDOM_CMDS / 2;
        n = 0;
        while (n < RANDOM_CMDS) begin
            burst    = $urandom_range(20, 60);
            mode     = $urandom_range(0, 2);
            gen_calm = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                if (n == sync_at) hold_next = 1'b1;
                add_random_cmd(mode);
                n++;
            end
        end
        cmds_total = cmd_queue.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_accepted < cmds_total) @(posedge i_clk);
        while (predicted_replies.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Command driver: predicts on acceptance, then presents the next transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_replies.insert(predicted_replies.size(), apply_command(cmd_on_bus));
                cmds_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_queue.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_queue[0].gap > 0) begin
                    cmd_queue[0].gap = cmd_queue[0].gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_queue[0].hold && predicted_replies.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    cmd_on_bus = cmd_queue[0];
                    cmd_queue.delete(0);
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, cmd_on_bus.pos, cmd_on_bus.val};
                    s_axis_tuser  <= cmd_on_bus.op;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin
        t_deq_reply got;
        t_deq_reply want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.front  = m_axis_tdata[31:0];
                got.back   = m_axis_tdata[63:32];
                got.count  = m_axis_tdata[68:64];
                if (predicted_replies.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    mismatches++;
                end else begin
                    want = predicted_replies[0];
                    predicted_replies.delete(0);
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.front !== want.front) begin
                        $error("front_value: expected %0d, actual %0d",
                               $signed(want.front), $signed(got.front));
                        mismatches++;
                    end
                    if (got.back !== want.back) begin
                        $error("back_value: expected %0d, actual %0d",
                               $signed(want.back), $signed(got.back));
                        mismatches++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, got.count);
                        mismatches++;
                    end
                end
                rx_results++;
                if (rx_results % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
                rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
                m_axis_tready <= (rx_wait == 0);
            end else if (!m_axis_tready) begin
                if (rx_wait > 0) rx_wait--;
                m_axis_tready <= (rx_wait == 0);
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
